/* sv/hrp_pkg.sv */
// Shared types, codes and token tables for the HTTP request parser.
package hrp_pkg;

   localparam int COUNT_BITS_DEFAULT = 31;
   localparam int BODY_LENGTH_BITS = 31;

   localparam logic [1:0] VERDICT_OK        = 2'd0;
   localparam logic [1:0] VERDICT_BAD       = 2'd1;
   localparam logic [1:0] VERDICT_FORBIDDEN = 2'd2;
   localparam logic [1:0] VERDICT_NOT_FOUND = 2'd3;

   localparam logic [2:0] TOK_GET     = 3'd0;
   localparam logic [2:0] TOK_POST    = 3'd1;
   localparam logic [2:0] TOK_INDEX   = 3'd2;
   localparam logic [2:0] TOK_IMAGE   = 3'd3;
   localparam logic [2:0] TOK_VERSION = 3'd4;
   localparam logic [2:0] TOK_CONN    = 3'd5;
   localparam logic [2:0] TOK_CLEN    = 3'd6;
   localparam logic [2:0] TOK_KEEP    = 3'd7;

   localparam int TOK_CHARS = 14;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]                  verdict;
      logic                        resource_id;
      logic                        keep_alive;
      logic [BODY_LENGTH_BITS-1:0] body_length;
   } rsp_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic logic [4:0] tok_len(input logic [2:0] id);
      logic [4:0] n;
      unique case (id)
         TOK_GET:     n = 5'd3;
         TOK_POST:    n = 5'd4;
         TOK_INDEX:   n = 5'd11;
         TOK_IMAGE:   n = 5'd11;
         TOK_VERSION: n = 5'd8;
         TOK_CONN:    n = 5'd10;
         TOK_CLEN:    n = 5'd14;
         TOK_KEEP:    n = 5'd10;
      endcase
      return n;
   endfunction

   // True when byte b at position pos breaks a match with token id.
   function automatic logic tok_miss(input logic [2:0] id, input logic [4:0] pos,
                                     input logic [7:0] b);
      logic [8*TOK_CHARS-1:0] s;
      logic [4:0]             n;
      logic [3:0]             k;
      logic [7:0]             c;
      logic                   miss;
      unique case (id)
         TOK_GET:     s = (8*TOK_CHARS)'("get");
         TOK_POST:    s = (8*TOK_CHARS)'("post");
         TOK_INDEX:   s = (8*TOK_CHARS)'("/index.html");
         TOK_IMAGE:   s = (8*TOK_CHARS)'("/image1.jpg");
         TOK_VERSION: s = (8*TOK_CHARS)'("http/1.1");
         TOK_CONN:    s = (8*TOK_CHARS)'("connection");
         TOK_CLEN:    s = (8*TOK_CHARS)'("content-length");
         TOK_KEEP:    s = (8*TOK_CHARS)'("keep-alive");
      endcase
      n = tok_len(id);
      k = 4'(n - 5'd1 - pos);
      c = s[{k, 3'b000} +: 8];
      if (pos >= n) begin
         miss = 1'b1;
      end else begin
         miss = (to_lower(b) != c);
      end
      return miss;
   endfunction

endpackage

/* sv/http_request_parser.sv */
// Streaming HTTP/1.1 request header parser with one verdict per request.
//
// Request channel: req_valid/req_stall carry one request byte per handshake
// in req_data, with final_byte set on the last byte of the request buffer.
// Response channel: rsp_valid/rsp_stall carry one verdict per request in
// rsp_data (verdict, resource_id, keep_alive, body_length).
// Each accepted byte updates the parse state in the same cycle; the verdict
// for a final byte is loaded into the response register at that edge, so it
// appears on rsp_valid in the cycle after the final byte is accepted.
// Throughput is one byte per cycle while req_stall is low.
// The response register holds its verdict while rsp_stall is high; if it holds
// a valid response then, req_stall rises and no byte is taken until it drains.
// Every byte, final or not, waits while a stalled response is held; bytes are
// accepted whenever the response register is free or being taken.
// Synchronous reset returns the parser to the method token and empties the
// response register; the parser also returns there after every final byte.
module http_request_parser #(
   parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrp_pkg::rsp_type rsp_data
);

   localparam int PROD_BITS = COUNT_BITS + 4;
   localparam int EXT_BITS = COUNT_BITS + 32;
   localparam int OUT_BITS = hrp_pkg::BODY_LENGTH_BITS;

   localparam logic [3:0] PH_METHOD     = 4'd0;
   localparam logic [3:0] PH_PATH       = 4'd1;
   localparam logic [3:0] PH_VERSION    = 4'd2;
   localparam logic [3:0] PH_LINE_LF    = 4'd3;
   localparam logic [3:0] PH_LINE_START = 4'd4;
   localparam logic [3:0] PH_NAME       = 4'd5;
   localparam logic [3:0] PH_CONN_SP    = 4'd6;
   localparam logic [3:0] PH_CONN_VAL   = 4'd7;
   localparam logic [3:0] PH_CLEN_SP    = 4'd8;
   localparam logic [3:0] PH_CLEN_VAL   = 4'd9;
   localparam logic [3:0] PH_OTHER      = 4'd10;
   localparam logic [3:0] PH_EMPTY_LF   = 4'd11;
   localparam logic [3:0] PH_BODY       = 4'd12;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [4:0] POS_MAX = 5'd31;

   logic [3:0]            phase_ff, phase_in;
   logic [1:0]            err_ff, err_in;
   logic                  err_seen_ff, err_seen_in;
   logic [4:0]            pos_ff, pos_in;
   logic [1:0]            match_ff, match_in;
   logic                  res_ff, res_in;
   logic                  keep_ff, keep_in;
   logic [COUNT_BITS-1:0] len_ff, len_in;
   logic [COUNT_BITS-1:0] body_ff, body_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   hrp_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic [7:0]            b;
   logic                  do_name, do_conn, do_clen;
   logic [PROD_BITS-1:0]  prod;
   logic [EXT_BITS-1:0]   len_ext;
   logic [1:0]            verdict;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !rsp_free;
   assign req_accept = req_valid && rsp_free;
   assign b          = req_data.data_byte;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign prod = PROD_BITS'({len_ff, 3'b000}) + PROD_BITS'({len_ff, 1'b0}) +
                 PROD_BITS'(b - CH_ZERO);

   always_comb begin
      phase_in    = phase_ff;
      err_in      = err_ff;
      err_seen_in = err_seen_ff;
      pos_in      = pos_ff;
      match_in    = match_ff;
      res_in      = res_ff;
      keep_in     = keep_ff;
      len_in      = len_ff;
      body_in     = body_ff;
      do_name     = 1'b0;
      do_conn     = 1'b0;
      do_clen     = 1'b0;

      if (!err_seen_ff) begin
         unique case (phase_ff)
            PH_METHOD: begin
               if (b == CH_SP) begin
                  if (match_ff[0] && pos_ff == hrp_pkg::tok_len(hrp_pkg::TOK_GET)) begin
                     phase_in = PH_PATH;
                     pos_in   = '0;
                     match_in = 2'b00;
                  end else if (match_ff[1] &&
                               pos_ff == hrp_pkg::tok_len(hrp_pkg::TOK_POST)) begin
                     err_seen_in = 1'b1;
                     err_in      = hrp_pkg::VERDICT_FORBIDDEN;
                  end else begin
                     err_seen_in = 1'b1;
                     err_in      = hrp_pkg::VERDICT_BAD;
                  end
               end else begin
                  match_in[0] = match_ff[0] && !hrp_pkg::tok_miss(hrp_pkg::TOK_GET, pos_ff, b);
                  match_in[1] = match_ff[1] && !hrp_pkg::tok_miss(hrp_pkg::TOK_POST, pos_ff, b);
                  pos_in      = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : pos_ff;
               end
            end
            PH_PATH: begin
               if (b == CH_SP) begin
                  if (match_ff[0] && pos_ff == hrp_pkg::tok_len(hrp_pkg::TOK_INDEX)) begin
                     res_in   = 1'b0;
                     phase_in = PH_VERSION;
                     pos_in   = '0;
                     match_in = 2'b01;
                  end else if (match_ff[1] &&
                               pos_ff == hrp_pkg::tok_len(hrp_pkg::TOK_IMAGE)) begin
                     res_in   = 1'b1;
                     phase_in = PH_VERSION;
                     pos_in   = '0;
                     match_in = 2'b01;
                  end else begin
                     err_seen_in = 1'b1;
                     err_in      = hrp_pkg::VERDICT_NOT_FOUND;
                  end
               end else if (b == CH_SLASH) begin
                  pos_in   = 5'd1;
                  match_in = 2'b11;
               end else begin
                  match_in[0] = match_ff[0] &&
                                !hrp_pkg::tok_miss(hrp_pkg::TOK_INDEX, pos_ff, b);
                  match_in[1] = match_ff[1] &&
                                !hrp_pkg::tok_miss(hrp_pkg::TOK_IMAGE, pos_ff, b);
                  pos_in      = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : pos_ff;
               end
            end
            PH_VERSION: begin
               if (b == CH_CR) begin
                  if (match_ff[0] && pos_ff == hrp_pkg::tok_len(hrp_pkg::TOK_VERSION)) begin
                     phase_in = PH_LINE_LF;
                  end else begin
                     err_seen_in = 1'b1;
                     err_in      = hrp_pkg::VERDICT_FORBIDDEN;
                  end
               end else begin
                  match_in[0] = match_ff[0] &&
                                !hrp_pkg::tok_miss(hrp_pkg::TOK_VERSION, pos_ff, b);
                  pos_in      = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : pos_ff;
               end
            end
            PH_LINE_LF: begin
               if (b == CH_LF) begin
                  phase_in = PH_LINE_START;
               end else begin
                  err_seen_in = 1'b1;
                  err_in      = hrp_pkg::VERDICT_BAD;
               end
            end
            PH_LINE_START: begin
               if (b == CH_CR) begin
                  phase_in = PH_EMPTY_LF;
               end else begin
                  do_name = 1'b1;
               end
            end
            PH_NAME: begin
               do_name = 1'b1;
            end
            PH_CONN_SP: begin
               if (b != CH_SP) begin
                  do_conn = 1'b1;
               end
            end
            PH_CONN_VAL: begin
               do_conn = 1'b1;
            end
            PH_CLEN_SP: begin
               if (b != CH_SP) begin
                  do_clen = 1'b1;
               end
            end
            PH_CLEN_VAL: begin
               do_clen = 1'b1;
            end
            PH_OTHER: begin
               if (b == CH_CR) begin
                  phase_in = PH_LINE_LF;
               end
            end
            PH_EMPTY_LF: begin
               if (b == CH_LF) begin
                  phase_in = PH_BODY;
               end else begin
                  err_seen_in = 1'b1;
                  err_in      = hrp_pkg::VERDICT_BAD;
               end
            end
            PH_BODY: begin
               if (body_ff != {COUNT_BITS{1'b1}}) begin
                  body_in = body_ff + 1'b1;
               end
            end
            default: begin
               err_seen_in = 1'b1;
               err_in      = hrp_pkg::VERDICT_BAD;
            end
         endcase
      end

      // Header name: a fresh line restarts both candidates at position zero.
      if (do_name) begin
         if (phase_ff == PH_LINE_START) begin
            pos_in   = '0;
            match_in = 2'b11;
         end
         if (b == CH_COLON) begin
            if (match_in[0] && pos_in == hrp_pkg::tok_len(hrp_pkg::TOK_CONN)) begin
               phase_in = PH_CONN_SP;
            end else if (match_in[1] && pos_in == hrp_pkg::tok_len(hrp_pkg::TOK_CLEN)) begin
               phase_in = PH_CLEN_SP;
            end else begin
               phase_in = PH_OTHER;
            end
         end else begin
            match_in[0] = match_in[0] && !hrp_pkg::tok_miss(hrp_pkg::TOK_CONN, pos_in, b);
            match_in[1] = match_in[1] && !hrp_pkg::tok_miss(hrp_pkg::TOK_CLEN, pos_in, b);
            pos_in      = (pos_in < POS_MAX) ? pos_in + 5'd1 : pos_in;
            phase_in    = PH_NAME;
         end
      end

      if (do_conn) begin
         if (phase_ff == PH_CONN_SP) begin
            pos_in   = '0;
            match_in = 2'b01;
         end
         if (b == CH_CR) begin
            if (match_in[0] && pos_in == hrp_pkg::tok_len(hrp_pkg::TOK_KEEP)) begin
               keep_in = 1'b1;
            end
            phase_in = PH_LINE_LF;
         end else begin
            match_in[0] = match_in[0] && !hrp_pkg::tok_miss(hrp_pkg::TOK_KEEP, pos_in, b);
            pos_in      = (pos_in < POS_MAX) ? pos_in + 5'd1 : pos_in;
            phase_in    = PH_CONN_VAL;
         end
      end

      // Content-Length digits: saturate the running value at all ones.
      if (do_clen) begin
         if (phase_ff == PH_CLEN_SP) begin
            len_in   = '0;
            pos_in   = '0;
            match_in = 2'b01;
         end
         if (b == CH_CR) begin
            phase_in = PH_LINE_LF;
         end else begin
            phase_in = PH_CLEN_VAL;
            if (match_in[0] && b >= CH_ZERO && b <= CH_NINE) begin
               if (phase_ff == PH_CLEN_SP) begin
                  len_in = COUNT_BITS'(b - CH_ZERO);
               end else if (|prod[PROD_BITS-1:COUNT_BITS]) begin
                  len_in = {COUNT_BITS{1'b1}};
               end else begin
                  len_in = prod[COUNT_BITS-1:0];
               end
            end else begin
               match_in[0] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (err_seen_in) begin
         verdict = err_in;
      end else if (phase_in != PH_BODY) begin
         verdict = hrp_pkg::VERDICT_BAD;
      end else if (body_in != '0 && body_in < len_in) begin
         verdict = hrp_pkg::VERDICT_BAD;
      end else begin
         verdict = hrp_pkg::VERDICT_OK;
      end
      len_ext                 = EXT_BITS'(len_in);
      rsp_data_in.verdict     = verdict;
      rsp_data_in.resource_id = (verdict == hrp_pkg::VERDICT_OK) ? res_in : 1'b0;
      rsp_data_in.keep_alive  = keep_in;
      rsp_data_in.body_length = (|len_ext[EXT_BITS-1:OUT_BITS]) ? {OUT_BITS{1'b1}}
                                                                : len_ext[OUT_BITS-1:0];
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (req_accept && req_data.final_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         err_ff       <= hrp_pkg::VERDICT_OK;
         err_seen_ff  <= 1'b0;
         pos_ff       <= '0;
         match_ff     <= 2'b11;
         res_ff       <= 1'b0;
         keep_ff      <= 1'b0;
         len_ff       <= '0;
         body_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            if (req_data.final_byte) begin
               phase_ff    <= PH_METHOD;
               err_ff      <= hrp_pkg::VERDICT_OK;
               err_seen_ff <= 1'b0;
               pos_ff      <= '0;
               match_ff    <= 2'b11;
               res_ff      <= 1'b0;
               keep_ff     <= 1'b0;
               len_ff      <= '0;
               body_ff     <= '0;
            end else begin
               phase_ff    <= phase_in;
               err_ff      <= err_in;
               err_seen_ff <= err_seen_in;
               pos_ff      <= pos_in;
               match_ff    <= match_in;
               res_ff      <= res_in;
               keep_ff     <= keep_in;
               len_ff      <= len_in;
               body_ff     <= body_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.final_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
